// ----- src/ise_pkg.sv -----
// Package with the shared types and constants of the insertion sort engine.
`timescale 1ns / 1ps

package ise_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH    = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         final_res;
      logic                         overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type                  op;
      logic signed [DATA_WIDTH-1:0] value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ----- src/ise_cell.sv -----
// One cell of the sorting chain, holding a single stored value.
`timescale 1ns / 1ps

module ise_cell
   import ise_pkg::*;
(
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic                         valid,
   input  logic                         below_valid,
   input  logic                         below_gt,
   input  logic signed [DATA_WIDTH-1:0] below_value,
   input  logic signed [DATA_WIDTH-1:0] above_value,
   output logic                         gt,
   output logic signed [DATA_WIDTH-1:0] value
);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   assign gt    = valid && (value_ff > ctl.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (below_gt) begin
               value_in = below_value;
            end else if (gt || (!valid && below_valid)) begin
               value_in = ctl.value;
            end
         end
         OP_SHIFT: begin
            value_in = above_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- src/insertion_sort_engine_top.sv -----
// Top level of the insertion sort engine: cell chain, fill count and drain control.
//
//   Channel  Direction  Payload    Handshake
//   req_     in         req_type   req_valid / req_stall
//   rsp_     out        rsp_type   rsp_valid / rsp_stall
//
// While a batch fills, one value is taken per cycle; every cell compares it with its
// own entry at once and the chain shifts in one step.
// The transaction flagged last is followed by one result per cycle while rsp_stall is
// low; the chain shifts down toward cell zero on each result, and req_stall stays high
// until the final result of the batch has gone out.
// Reset empties the chain and clears the overflow flag.
`timescale 1ns / 1ps

module insertion_sort_engine_top
   import ise_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   cell_ctl_type  ctl;
   logic          req_acc, rsp_acc, full;

   logic                         cell_valid [DEPTH];
   logic                         cell_gt    [DEPTH];
   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];

   assign full      = (fill_ff == CW'(DEPTH));
   assign req_stall = (state_ff != ST_FILL);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.final_res    = (fill_ff == CW'(1));
   assign rsp_data.overflowed   = ovf_ff;

   always_comb begin
      ctl.value = req_data.value;
      ctl.op    = OP_HOLD;
      if (req_acc && !full) begin
         ctl.op = OP_INSERT;
      end else if (rsp_acc) begin
         ctl.op = OP_SHIFT;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_acc) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
               if (req_data.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_acc) begin
               fill_in = fill_ff - CW'(1);
               if (fill_ff == CW'(1)) begin
                  state_in = ST_FILL;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (CW'(i) < fill_ff);

      ise_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .valid       (cell_valid[i]),
         .below_valid ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i - 1]),
         .below_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
         .below_value (cell_value[(i == 0) ? 0 : i - 1]),
         .above_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
         .gt          (cell_gt[i]),
         .value       (cell_value[i])
      );
   end

endmodule
